### hw/rtl/ipv4_header_checker_assert.svh
// Assertion macros used by the checker's top-level RTL file.
`ifndef IPV4_HEADER_CHECKER_ASSERT_SVH
`define IPV4_HEADER_CHECKER_ASSERT_SVH

// Same-cycle implication, sampled on clk and quiet during rst.
`define IPV4HC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ipv4 header checker assertion failed");

// Next-cycle implication, sampled on clk and quiet during rst.
`define IPV4HC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ipv4 header checker assertion failed");

`endif

### hw/rtl/ipv4hc_pkg.sv
package ipv4hc_pkg;

  // One input word of the header stream.
  typedef struct packed {
    logic [15:0] header_word;
    logic        first_word;
  } in_word_t;

  // One verdict word.
  typedef struct packed {
    logic [2:0] verdict;
    logic [1:0] protocol_class;
    logic [7:0] protocol_number;
    logic [3:0] header_length_words;
  } verdict_word_t;

  // Verdict codes, in the order the checks are applied.
  localparam logic [2:0] VERDICT_ACCEPT   = 3'd0;
  localparam logic [2:0] VERDICT_VERSION  = 3'd1;
  localparam logic [2:0] VERDICT_SHORT    = 3'd2;
  localparam logic [2:0] VERDICT_TTL      = 3'd3;
  localparam logic [2:0] VERDICT_CHECKSUM = 3'd4;
  localparam logic [2:0] VERDICT_FLAGS    = 3'd5;
  localparam logic [2:0] VERDICT_PROTOCOL = 3'd6;

  // Protocol classes.
  localparam logic [1:0] CLASS_ICMP  = 2'd0;
  localparam logic [1:0] CLASS_TCP   = 2'd1;
  localparam logic [1:0] CLASS_UDP   = 2'd2;
  localparam logic [1:0] CLASS_OTHER = 2'd3;

  // Protocol numbers and header constants.
  localparam logic [7:0]  PROTO_ICMP   = 8'd1;
  localparam logic [7:0]  PROTO_TCP    = 8'd6;
  localparam logic [7:0]  PROTO_UDP    = 8'd17;
  localparam logic [3:0]  IP_VERSION   = 4'd4;
  localparam logic [3:0]  MIN_IHL      = 4'd5;
  localparam logic [15:0] SUM_GOOD     = 16'hffff;
  localparam logic [4:0]  WORD_FLAGS   = 5'd3;
  localparam logic [4:0]  WORD_TTL     = 5'd4;

  // Ones-complement add with end-around carry.
  function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[15:0] + {15'd0, s[16]};
  endfunction

endpackage

### hw/rtl/ipv4hc_track.sv
// Header state: running checksum, field capture, word count and the verdict.
module ipv4hc_track (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    go,
  input  ipv4hc_pkg::in_word_t    word,
  output logic                    emit,
  output ipv4hc_pkg::verdict_word_t result
);

  logic        in_header;
  logic [4:0]  words_seen;
  logic [15:0] running_sum;
  logic [3:0]  version_seen;
  logic [3:0]  ihl_seen;
  logic [2:0]  flags_seen;
  logic [7:0]  ttl_seen;
  logic [7:0]  proto_seen;

  logic        open;
  logic [4:0]  words_base;
  logic [4:0]  words_seen_next;
  logic [15:0] running_sum_next;
  logic [3:0]  version_seen_next;
  logic [3:0]  ihl_seen_next;
  logic [2:0]  flags_seen_next;
  logic [7:0]  ttl_seen_next;
  logic [7:0]  proto_seen_next;
  logic [3:0]  ihl_eff;
  logic        done;
  logic [1:0]  cls;

  always_comb begin
    open              = word.first_word || in_header;
    words_base        = word.first_word ? 5'd0 : words_seen;
    version_seen_next = word.first_word ? word.header_word[15:12] : version_seen;
    ihl_seen_next     = word.first_word ? word.header_word[11:8] : ihl_seen;
    flags_seen_next   = word.first_word ? 3'd0 : flags_seen;
    ttl_seen_next     = word.first_word ? 8'd0 : ttl_seen;
    proto_seen_next   = word.first_word ? 8'd0 : proto_seen;
    if (words_base == ipv4hc_pkg::WORD_FLAGS) begin
      flags_seen_next = word.header_word[15:13];
    end else if (words_base == ipv4hc_pkg::WORD_TTL) begin
      ttl_seen_next   = word.header_word[15:8];
      proto_seen_next = word.header_word[7:0];
    end
    running_sum_next = ipv4hc_pkg::oc_add(word.first_word ? 16'd0 : running_sum,
                                          word.header_word);
    words_seen_next  = words_base + 5'd1;

    // A short header is treated as five 32-bit words long.
    ihl_eff = (ihl_seen_next < ipv4hc_pkg::MIN_IHL) ? ipv4hc_pkg::MIN_IHL : ihl_seen_next;
    done    = open && (words_seen_next >= {ihl_eff, 1'b0});
    emit    = done;

    if (proto_seen_next == ipv4hc_pkg::PROTO_ICMP) begin
      cls = ipv4hc_pkg::CLASS_ICMP;
    end else if (proto_seen_next == ipv4hc_pkg::PROTO_TCP) begin
      cls = ipv4hc_pkg::CLASS_TCP;
    end else if (proto_seen_next == ipv4hc_pkg::PROTO_UDP) begin
      cls = ipv4hc_pkg::CLASS_UDP;
    end else begin
      cls = ipv4hc_pkg::CLASS_OTHER;
    end

    if (version_seen_next != ipv4hc_pkg::IP_VERSION) begin
      result.verdict = ipv4hc_pkg::VERDICT_VERSION;
    end else if (ihl_seen_next < ipv4hc_pkg::MIN_IHL) begin
      result.verdict = ipv4hc_pkg::VERDICT_SHORT;
    end else if (ttl_seen_next == 8'd0) begin
      result.verdict = ipv4hc_pkg::VERDICT_TTL;
    end else if (running_sum_next != ipv4hc_pkg::SUM_GOOD) begin
      result.verdict = ipv4hc_pkg::VERDICT_CHECKSUM;
    end else if (flags_seen_next != 3'd0) begin
      result.verdict = ipv4hc_pkg::VERDICT_FLAGS;
    end else if (cls == ipv4hc_pkg::CLASS_OTHER) begin
      result.verdict = ipv4hc_pkg::VERDICT_PROTOCOL;
    end else begin
      result.verdict = ipv4hc_pkg::VERDICT_ACCEPT;
    end
    result.protocol_class      = cls;
    result.protocol_number     = proto_seen_next;
    result.header_length_words = ihl_seen_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_header    <= 1'b0;
      words_seen   <= 5'd0;
      running_sum  <= 16'd0;
      version_seen <= 4'd0;
      ihl_seen     <= 4'd0;
      flags_seen   <= 3'd0;
      ttl_seen     <= 8'd0;
      proto_seen   <= 8'd0;
    end else if (go && open) begin
      in_header    <= !done;
      words_seen   <= words_seen_next;
      running_sum  <= running_sum_next;
      version_seen <= version_seen_next;
      ihl_seen     <= ihl_seen_next;
      flags_seen   <= flags_seen_next;
      ttl_seen     <= ttl_seen_next;
      proto_seen   <= proto_seen_next;
    end
  end

endmodule

### hw/rtl/ipv4hc_outreg.sv
// Result register holding one verdict word until the receiver takes it.
module ipv4hc_outreg (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      load,
  input  ipv4hc_pkg::verdict_word_t din,
  output logic                      free,
  output logic                      valid,
  input  logic                      ready,
  output ipv4hc_pkg::verdict_word_t data
);

  assign free = !valid || ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data <= din;
    end
  end

endmodule

### hw/rtl/ipv4_header_checker.sv
// IPv4 header checker.
// Header words enter on the word channel (word_valid, word_ready, word_data), one
// 16-bit big-endian word per cycle; first_word marks the first word of a header.
// Words that arrive while no header is open are dropped without a result.
// After the last header word (ihl*2 words, or ten words when ihl is below five)
// one verdict word leaves on the verdict channel (verdict_valid, verdict_ready,
// verdict_data) carrying the verdict code, protocol class and number, and ihl.
// Path: a word is registered at the input, then checked and summed in the check
// stage, and its verdict is registered in the verdict register before it is offered.
// Throughput: one word per cycle; the running ones-complement sum is a single
// 16-bit end-around-carry add in the check stage, which sets the cycle.
// When the receiver stalls, the verdict register holds its word; words that
// close no header keep flowing, and a word that would close a header waits in
// the input register until the verdict register frees, with word_ready low
// for as long as it waits.
// Reset (rst, synchronous) empties both registers and closes any open header.
module ipv4_header_checker (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      word_valid,
  output logic                      word_ready,
  input  ipv4hc_pkg::in_word_t      word_data,
  output logic                      verdict_valid,
  input  logic                      verdict_ready,
  output ipv4hc_pkg::verdict_word_t verdict_data
);

`include "ipv4_header_checker_assert.svh"

  // Input register.
  logic                      s1_valid;
  ipv4hc_pkg::in_word_t      s1_word;

  logic                      s1_go;
  logic                      emit;
  logic                      out_free;
  logic                      out_load;
  ipv4hc_pkg::verdict_word_t result;

  // The staged word moves on when it yields no verdict, or when the verdict
  // register can take its result.
  assign s1_go      = s1_valid && (!emit || out_free);
  assign word_ready = !s1_valid || s1_go;
  assign out_load   = s1_go && emit;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (word_valid && word_ready) begin
      s1_valid <= 1'b1;
    end else if (s1_go) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (word_valid && word_ready) begin
      s1_word <= word_data;
    end
  end

  ipv4hc_track u_track (
    .clk    (clk),
    .rst    (rst),
    .go     (s1_go),
    .word   (s1_word),
    .emit   (emit),
    .result (result)
  );

  ipv4hc_outreg u_outreg (
    .clk   (clk),
    .rst   (rst),
    .load  (out_load),
    .din   (result),
    .free  (out_free),
    .valid (verdict_valid),
    .ready (verdict_ready),
    .data  (verdict_data)
  );

  // A staged word that cannot move on stays put.
  `IPV4HC_ASSERT_NEXT(a_s1_hold, s1_valid && !s1_go, s1_valid && $stable(s1_word))
  // A loaded result is presented on the next cycle.
  `IPV4HC_ASSERT_NEXT(a_load_shows, out_load, verdict_valid)
  // An accepted header always names a known protocol.
  `IPV4HC_ASSERT_NOW(a_accept_class,
    verdict_valid && verdict_data.verdict == ipv4hc_pkg::VERDICT_ACCEPT,
    verdict_data.protocol_class != ipv4hc_pkg::CLASS_OTHER)
  // A short-header verdict only comes with an ihl below five.
  `IPV4HC_ASSERT_NOW(a_short_ihl,
    verdict_valid && verdict_data.verdict == ipv4hc_pkg::VERDICT_SHORT,
    verdict_data.header_length_words < ipv4hc_pkg::MIN_IHL)

endmodule
